>>> src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in the same cycle as b, outside reset
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a is followed by b in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// a is followed by b in the next cycle, also across reset
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> src/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int VALUE_W = 31;
  localparam int STEP_W  = 5;

  typedef logic [VALUE_W-1:0] value_t;

  // controller to datapath
  typedef struct packed {
    logic load_cand;
    logic rd_en;
    logic div_start;
    logic inc_idx;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
    logic div_done;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> src/pipelined_prime_sieve_unit.sv
// Prime sieve by trial division against the primes found so far.
// Input channel in_valid/in_ready carries one candidate per transfer; the
// output channel out_valid/out_ready carries prime_value and store_full.
// A candidate is divided by each stored prime in order of discovery in one
// shared one-bit-per-cycle remainder unit.
// If a stored prime divides it, the candidate is dropped with no result.
// Otherwise it is written to the prime memory (when not yet full) and
// loaded into the output register, which raises out_valid; the list holds
// at most PRIME_SLOTS primes. The next candidate is taken once a survivor
// has been emitted, or once a stored prime has divided the one before.
// When the memory already holds PRIME_SLOTS primes, the result carries
// store_full = 1 and nothing is stored.
// One candidate is in work at a time; in_ready is high only between items.
// The output register lets the next candidate enter while a result waits;
// a stalled receiver holds the result, and a new survivor waits for it.
// Reset empties the prime list and the output register at once; there is
// no clearing pass over the memory.
`timescale 1ns / 1ps
`default_nettype none

module pipelined_prime_sieve_unit #(
  parameter int PRIME_SLOTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pps_pkg::VALUE_W-1:0] candidate,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pps_pkg::VALUE_W-1:0]      prime_value,
  output logic                             store_full
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pps_datapath #(
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .candidate   (candidate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_value (prime_value),
    .store_full  (store_full)
  );

endmodule

`default_nettype wire

>>> src/pps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/pps_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one quotient bit per cycle; a zero divisor leaves the dividend
module pps_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire pps_pkg::value_t dividend,
  input  wire pps_pkg::value_t divisor,
  output logic                done,
  output pps_pkg::value_t     remainder
);

  logic                        busy;
  logic [pps_pkg::STEP_W-1:0]  step;
  pps_pkg::value_t             quo;
  pps_pkg::value_t             dvs;
  logic [pps_pkg::VALUE_W:0]   rem_sh;
  logic [pps_pkg::VALUE_W:0]   diff;

  assign rem_sh = {remainder, quo[pps_pkg::VALUE_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= pps_pkg::STEP_W'(pps_pkg::VALUE_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[pps_pkg::VALUE_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs}) begin
        remainder <= diff[pps_pkg::VALUE_W-1:0];
      end else begin
        remainder <= rem_sh[pps_pkg::VALUE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath #(
  parameter int PRIME_SLOTS = 64,
  localparam int IDX_W = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1,
  localparam int CNT_W = $clog2(PRIME_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pps_pkg::cmd_t    cmd,
  output pps_pkg::status_t      status,
  input  wire pps_pkg::value_t  candidate,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pps_pkg::value_t       prime_value,
  output logic                  store_full
);

  pps_pkg::value_t  cand;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic             full;
  pps_pkg::value_t  stored;
  pps_pkg::value_t  rem;
  logic             div_done;

  assign full = (count == CNT_W'(PRIME_SLOTS));

  pps_ram #(
    .WIDTH (pps_pkg::VALUE_W),
    .DEPTH (PRIME_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.emit && !full),
    .waddr (count[IDX_W-1:0]),
    .wdata (cand),
    .re    (cmd.rd_en),
    .raddr (idx[IDX_W-1:0]),
    .rdata (stored)
  );

  pps_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (cand),
    .divisor   (stored),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_cand) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cand) begin
      cand <= candidate;
    end
    if (cmd.emit) begin
      prime_value <= cand;
      store_full  <= full;
    end
  end

  assign status.at_end   = (idx == count);
  assign status.div_done = div_done;
  assign status.rem_zero = (rem == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> src/pps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pps_pkg::status_t status,
  output pps_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_cand = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.at_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            // divisible: drop the candidate
            state_next = S_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = S_CHECK;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/pps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pps_pkg::VALUE_W-1:0] prime_value,
  input wire logic                        store_full
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(prime_value) && $stable(store_full))
  `ASSERT_SAME(a_idle_known, clk, rst, in_ready, !$isunknown(in_ready) && !$isunknown(out_valid))

endmodule

bind pipelined_prime_sieve_unit pps_checker u_pps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .prime_value (prime_value),
  .store_full  (store_full)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  typedef pps_pkg::value_t value_t;

  localparam int PRIME_SLOTS  = 64;
  localparam int HOLD_CYCLES  = 1500;
  // one candidate against a full list, with margin
  localparam int DRAIN_CYCLES = 34 * (PRIME_SLOTS + 1) + 64;
  localparam int STALL_LIMIT  = 30000;
  localparam int RANDOM_ITEMS = 272;

  typedef struct packed {
    value_t prime;
    logic   overflow;
  } sieve_result_t;

  // trial division against the primes found so far, in order of discovery
  class sieve_scoreboard;
    value_t          primes_found[PRIME_SLOTS];
    int unsigned     n_stored;
    sieve_result_t   expected_q[$];
    int unsigned     errors;

    function void note_candidate(value_t cand);
      sieve_result_t res;
      value_t        rem;
      for (int i = 0; i < n_stored; i++) begin
        // a zero divisor leaves the dividend as remainder
        rem = (primes_found[i] == '0) ? cand : cand % primes_found[i];
        if (rem == '0) return;
      end
      res.prime    = cand;
      res.overflow = (n_stored >= PRIME_SLOTS);
      if (!res.overflow) begin
        primes_found[n_stored] = cand;
        n_stored++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(value_t got_prime, logic got_full);
      sieve_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none pending: prime_value=%0d store_full=%0b",
                 $time, got_prime, got_full);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got_prime !== want.prime) begin
        $display("%0t: prime_value mismatch: expected %0d, actual %0d",
                 $time, want.prime, got_prime);
        errors++;
      end
      if (got_full !== want.overflow) begin
        $display("%0t: store_full mismatch: expected %0b, actual %0b",
                 $time, want.overflow, got_full);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  value_t candidate = '0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  value_t prime_value;
  logic   store_full;

  logic   steady = 1'b0;
  logic   rx_hold = 1'b0;
  int     quiet_cycles = 0;
  sieve_scoreboard board = new();

  pipelined_prime_sieve_unit #(
    .PRIME_SLOTS(PRIME_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .candidate  (candidate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_value(prime_value),
    .store_full (store_full)
  );

  always #6 clk = ~clk;

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_candidate(input value_t cand);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= cand;
    do @(negedge clk); while (!in_ready);
    board.note_candidate(cand);
    @(posedge clk);
  endtask

  // stop offering until every pending result is out and the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // outputs and handshakes are sampled mid-cycle, where they are settled
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_result(prime_value, store_full);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("** pipelined_prime_sieve_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    value_t next_odd;
    int     pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first candidate is stored as zero, which then only divides zero
    send_candidate('0);
    send_candidate('0);
    // the receiver stalls, so a survivor waits behind the held result
    rx_hold = 1'b1;
    send_candidate(31'd2);
    send_candidate(31'd3);
    send_candidate(31'h7FFF_FFFF);
    send_candidate(31'd5);
    send_candidate(31'd7);
    send_candidate(31'd4);
    send_candidate(31'd9);
    send_candidate(31'd25);
    send_candidate(31'd49);
    send_candidate(31'h7FFF_FFFE);
    send_candidate(31'h4000_0000);
    send_candidate(31'h5555_5555);
    send_candidate(31'h2AAA_AAAA);
    send_candidate('0);
    send_candidate(31'd11);
    send_candidate(31'd13);
    send_candidate(31'h7FFF_FFFF);
    drain_results();

    // mostly the odd number stream, with random values mixed in
    next_odd = 31'd9;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      steady <= (k >= 120 && k < 170);
      pick = $urandom_range(0, 99);
      if (k == RANDOM_ITEMS - 1) begin
        send_candidate(31'd1);
      end else if (pick < 80) begin
        send_candidate(next_odd);
        next_odd = next_odd + 31'd2;
      end else if (pick < 92) begin
        send_candidate(value_t'($urandom));
      end else begin
        send_candidate(value_t'($urandom_range(0, 3000)));
      end
    end
    steady <= 1'b0;

    drain_results();
    if (board.errors == 0 && board.pending() == 0)
      $display("** pipelined_prime_sieve_unit: PASSED **");
    else
      $display("** pipelined_prime_sieve_unit: FAILED **");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/pps_pkg.sv
src/pps_ram.sv
src/pps_divider.sv
src/pps_datapath.sv
src/pps_ctrl.sv
src/pipelined_prime_sieve_unit.sv
src/pps_checker.sv
tb/tb.sv
